FILE: rtl/lpg_pkg.sv
// Package for the line pixel generator: field widths, reset values,
// operation and register codes, and the small structs shared by the modules.
// No dependencies.
package lpg_pkg;

   localparam int DEFAULT_COORD_BITS = 12;
   localparam int DIM_BITS           = 11;
   localparam int INDEX_BITS         = 22;
   localparam int COLOUR_BITS        = 8;
   localparam int CSR_INDEX_BITS     = 2;

   localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET  = 11'd800;
   localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = 11'd600;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // Input operation codes.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   typedef struct packed {
      logic [COLOUR_BITS-1:0] red;
      logic [COLOUR_BITS-1:0] green;
      logic [COLOUR_BITS-1:0] blue;
   } colour_type;

   // Per-pixel attributes that travel with the coordinates of a step.
   typedef struct packed {
      colour_type colour;
      logic       last;
   } pixel_info_type;

endpackage

FILE: rtl/lpg_line_state.sv
// Line setup and stepping state of the line pixel generator.
// A load sets up the Bresenham terms; a step presents the current pixel and
// advances. Depends on lpg_pkg.
module lpg_line_state #(
   parameter int COORD_BITS = lpg_pkg::DEFAULT_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic                          step,
   input  logic signed [COORD_BITS-1:0]  x_start,
   input  logic signed [COORD_BITS-1:0]  y_start,
   input  logic signed [COORD_BITS-1:0]  x_end,
   input  logic signed [COORD_BITS-1:0]  y_end,
   input  lpg_pkg::colour_type           colour,
   output logic                          line_active,
   output logic signed [COORD_BITS-1:0]  pixel_x,
   output logic signed [COORD_BITS-1:0]  pixel_y,
   output lpg_pkg::pixel_info_type       pixel_info
);
   import lpg_pkg::*;

   localparam int D = COORD_BITS + 1;   // deltas and span
   localparam int E = COORD_BITS + 2;   // error terms
   localparam int A = COORD_BITS + 3;   // error sum before correction

   logic                         line_active_ff, line_active_in;
   logic                         steep_ff, steep_in;
   logic signed [COORD_BITS-1:0] major_pos_ff, major_pos_in;
   logic signed [COORD_BITS-1:0] major_last_ff, major_last_in;
   logic signed [COORD_BITS-1:0] minor_pos_ff, minor_pos_in;
   logic                         minor_down_ff, minor_down_in;
   logic signed [E-1:0]          error_acc_ff, error_acc_in;
   logic [D-1:0]                 major_span_ff, major_span_in;
   logic [E-1:0]                 error_incr_ff, error_incr_in;
   colour_type                   colour_ff, colour_in;

   logic signed [D-1:0] dx, dy, dm, dn;
   logic [D-1:0]        adx, ady, adm, adn;
   logic                steep, swap, dn_pos, dn_neg;
   logic signed [A-1:0] acc_sum, acc_fixed;
   logic                is_last;

   // Setup: both deltas and their magnitudes are formed in parallel, so the
   // span and the increment need no second subtraction after the swap.
   assign dx  = D'(x_end) - D'(x_start);
   assign dy  = D'(y_end) - D'(y_start);
   assign adx = dx[D-1] ? D'(-dx) : D'(dx);
   assign ady = dy[D-1] ? D'(-dy) : D'(dy);
   assign steep = adx < ady;
   assign dm  = steep ? dy : dx;
   assign dn  = steep ? dx : dy;
   assign adm = steep ? ady : adx;
   assign adn = steep ? adx : ady;
   assign swap   = dm[D-1];
   assign dn_neg = dn[D-1];
   assign dn_pos = !dn[D-1] && (dn != '0);

   // Stepping: error sum and its correction when the minor axis moves.
   assign is_last   = major_pos_ff == major_last_ff;
   assign acc_sum   = A'(error_acc_ff) + $signed(A'(error_incr_ff));
   assign acc_fixed = acc_sum - $signed(A'({major_span_ff, 1'b0}));

   always_comb begin
      line_active_in = line_active_ff;
      steep_in       = steep_ff;
      major_pos_in   = major_pos_ff;
      major_last_in  = major_last_ff;
      minor_pos_in   = minor_pos_ff;
      minor_down_in  = minor_down_ff;
      error_acc_in   = error_acc_ff;
      major_span_in  = major_span_ff;
      error_incr_in  = error_incr_ff;
      colour_in      = colour_ff;
      if (load) begin
         line_active_in = 1'b1;
         steep_in       = steep;
         if (steep) begin
            major_pos_in  = swap ? y_end : y_start;
            major_last_in = swap ? y_start : y_end;
            minor_pos_in  = swap ? x_end : x_start;
         end else begin
            major_pos_in  = swap ? x_end : x_start;
            major_last_in = swap ? x_start : x_end;
            minor_pos_in  = swap ? y_end : y_start;
         end
         // After the swap the minor delta changes sign.
         minor_down_in  = !(swap ? dn_neg : dn_pos);
         major_span_in  = adm;
         error_incr_in  = {adn, 1'b0};
         error_acc_in   = '0;
         colour_in      = colour;
      end else if (step && line_active_ff) begin
         if (is_last) begin
            line_active_in = 1'b0;
         end else begin
            major_pos_in = major_pos_ff + COORD_BITS'(1);
            if (acc_sum > $signed(A'(major_span_ff))) begin
               minor_pos_in = minor_down_ff ? minor_pos_ff - COORD_BITS'(1)
                                            : minor_pos_ff + COORD_BITS'(1);
               error_acc_in = acc_fixed[E-1:0];
            end else begin
               error_acc_in = acc_sum[E-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
      end else begin
         line_active_ff <= line_active_in;
      end
      steep_ff      <= steep_in;
      major_pos_ff  <= major_pos_in;
      major_last_ff <= major_last_in;
      minor_pos_ff  <= minor_pos_in;
      minor_down_ff <= minor_down_in;
      error_acc_ff  <= error_acc_in;
      major_span_ff <= major_span_in;
      error_incr_ff <= error_incr_in;
      colour_ff     <= colour_in;
   end

   assign line_active       = line_active_ff;
   assign pixel_x           = steep_ff ? minor_pos_ff : major_pos_ff;
   assign pixel_y           = steep_ff ? major_pos_ff : minor_pos_ff;
   assign pixel_info.colour = colour_ff;
   assign pixel_info.last   = is_last;

endmodule

FILE: rtl/lpg_pixel_clip.sv
// Frame clipping and linear frame index for one pixel of the line.
// Purely combinational. Depends on lpg_pkg.
module lpg_pixel_clip #(
   parameter int COORD_BITS = lpg_pkg::DEFAULT_COORD_BITS
) (
   input  logic signed [COORD_BITS-1:0]   pixel_x,
   input  logic signed [COORD_BITS-1:0]   pixel_y,
   input  logic [lpg_pkg::DIM_BITS-1:0]   frame_width,
   input  logic [lpg_pkg::DIM_BITS-1:0]   frame_height,
   output logic                           in_frame,
   output logic [lpg_pkg::INDEX_BITS-1:0] pixel_index
);
   import lpg_pkg::*;

   localparam int CMP_BITS  = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
   localparam int PROD_BITS = DIM_BITS + COORD_BITS + 1;
   localparam int SUM_BITS  = (PROD_BITS > INDEX_BITS) ? PROD_BITS : INDEX_BITS;

   logic [COORD_BITS-1:0] x_u, y_u;
   logic                  x_ok, y_ok;
   logic [SUM_BITS-1:0]   index_full;

   assign x_u = $unsigned(pixel_x);
   assign y_u = $unsigned(pixel_y);

   // The sign bit is checked first, so the magnitude compare is unsigned.
   assign x_ok = !pixel_x[COORD_BITS-1] && (CMP_BITS'(x_u) < CMP_BITS'(frame_width));
   assign y_ok = !pixel_y[COORD_BITS-1] && (CMP_BITS'(y_u) < CMP_BITS'(frame_height));
   assign in_frame = x_ok && y_ok;

   assign index_full  = SUM_BITS'(frame_width) * SUM_BITS'(y_u) + SUM_BITS'(x_u);
   assign pixel_index = in_frame ? index_full[INDEX_BITS-1:0] : '0;

endmodule

FILE: rtl/lpg_out_buffer.sv
// Output register with a skid entry for the result channel.
// The upstream stall is taken from the skid flag, so it is registered.
// No package dependency.
module lpg_out_buffer #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             in_stall,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data,
   input  logic             out_stall
);
   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [WIDTH-1:0] out_data_ff, out_data_in;
   logic [WIDTH-1:0] skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || !out_stall) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_data_in  = in_data;
            out_valid_in = in_valid;
         end
      end else if (in_valid) begin
         skid_data_in  = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

FILE: rtl/line_pixel_generator.sv
// Top level of the line pixel generator: configuration registers, line state,
// clipping and the output buffer. Depends on lpg_pkg, lpg_line_state,
// lpg_pixel_clip and lpg_out_buffer.

// The block rasterizes one line at a time with the integer Bresenham method.
// A load transfer (operation 0) takes two signed endpoints and a colour and
// replaces any line in progress; it gives no result. Each step transfer
// (operation 1) while a line is active gives exactly one pixel, walking from
// the lower end of the major axis to the upper end inclusive, with last_pixel
// set on the final one; a step with no active line is consumed silently.
// Pixels off the frame set by frame_width and frame_height are still
// delivered, with in_frame 0 and pixel_index 0. A load may be followed by a
// step in the very next cycle, so while req_stall is low the block sustains
// one pixel per clock. A pixel goes to the result channel through the output
// register, or under a stall through the skid entry first; the line state
// register and the output register are the only stages. A two-entry output
// buffer absorbs a stall on the result side, and req_stall rises only once
// both entries are full. Write frame_width and frame_height only while idle.
module line_pixel_generator #(
   parameter int COORD_BITS = lpg_pkg::DEFAULT_COORD_BITS
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_operation,
   input  logic signed [COORD_BITS-1:0]       req_x_start,
   input  logic signed [COORD_BITS-1:0]       req_y_start,
   input  logic signed [COORD_BITS-1:0]       req_x_end,
   input  logic signed [COORD_BITS-1:0]       req_y_end,
   input  logic [lpg_pkg::COLOUR_BITS-1:0]    req_red_in,
   input  logic [lpg_pkg::COLOUR_BITS-1:0]    req_green_in,
   input  logic [lpg_pkg::COLOUR_BITS-1:0]    req_blue_in,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [COORD_BITS-1:0]       rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]       rsp_pixel_y,
   output logic [lpg_pkg::INDEX_BITS-1:0]     rsp_pixel_index,
   output logic [lpg_pkg::COLOUR_BITS-1:0]    rsp_red_out,
   output logic [lpg_pkg::COLOUR_BITS-1:0]    rsp_green_out,
   output logic [lpg_pkg::COLOUR_BITS-1:0]    rsp_blue_out,
   output logic                               rsp_in_frame,
   output logic                               rsp_last_pixel,

   input  logic                               csr_write,
   input  logic [lpg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lpg_pkg::DIM_BITS-1:0]       csr_wdata
);
   import lpg_pkg::*;

   localparam int OUT_BITS = 2 * COORD_BITS + INDEX_BITS + 3 * COLOUR_BITS + 2;

   logic [DIM_BITS-1:0] frame_width_ff, frame_width_in;
   logic [DIM_BITS-1:0] frame_height_ff, frame_height_in;

   logic                         req_transfer, load, step, line_active, produce;
   colour_type                   req_colour;
   logic signed [COORD_BITS-1:0] pixel_x, pixel_y;
   pixel_info_type               pixel_info;
   logic                         in_frame;
   logic [INDEX_BITS-1:0]        pixel_index;
   logic [OUT_BITS-1:0]          result_data, rsp_data;

   // Configuration registers; writes to unknown indexes fall through.
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   assign req_transfer = req_valid && !req_stall;
   assign load         = req_transfer && (req_operation == OP_LOAD);
   assign step         = req_transfer && (req_operation == OP_STEP);
   // Only a step that finds a line in progress makes a pixel.
   assign produce      = step && line_active;

   assign req_colour.red   = req_red_in;
   assign req_colour.green = req_green_in;
   assign req_colour.blue  = req_blue_in;

   lpg_line_state #(
      .COORD_BITS (COORD_BITS)
   ) u_line_state (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .step        (step),
      .x_start     (req_x_start),
      .y_start     (req_y_start),
      .x_end       (req_x_end),
      .y_end       (req_y_end),
      .colour      (req_colour),
      .line_active (line_active),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .pixel_info  (pixel_info)
   );

   lpg_pixel_clip #(
      .COORD_BITS (COORD_BITS)
   ) u_pixel_clip (
      .pixel_x      (pixel_x),
      .pixel_y      (pixel_y),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .in_frame     (in_frame),
      .pixel_index  (pixel_index)
   );

   assign result_data = {pixel_x, pixel_y, pixel_index, pixel_info.colour.red,
                         pixel_info.colour.green, pixel_info.colour.blue,
                         in_frame, pixel_info.last};

   lpg_out_buffer #(
      .WIDTH (OUT_BITS)
   ) u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (produce),
      .in_data   (result_data),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

   assign {rsp_pixel_x, rsp_pixel_y, rsp_pixel_index, rsp_red_out, rsp_green_out,
           rsp_blue_out, rsp_in_frame, rsp_last_pixel} = rsp_data;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for line_pixel_generator: load and step transfers go
// in, every pixel coming out is compared with a behavioral Bresenham rasterizer.
// Depends on lpg_pkg and the line_pixel_generator RTL.
module tb_top;
   import lpg_pkg::*;

   localparam int CB              = DEFAULT_COORD_BITS;
   localparam int COORD_MIN       = -(1 << (CB - 1));
   localparam int COORD_MAX       = (1 << (CB - 1)) - 1;
   localparam int PHASES          = 7;
   localparam int ITEMS_PER_PHASE = 155;
   // The block has one register stage plus a two-entry output buffer, so the
   // settle wait after the last pixel is plenty for it to go quiet.
   localparam int SETTLE_CYCLES   = 6;
   localparam int QUIET_LIMIT     = 2000;

   // Register indexes with nothing behind them; writes there must be ignored.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_2 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_3 = 2'd3;

   typedef struct {
      logic                   op;
      logic signed [CB-1:0]   xs;
      logic signed [CB-1:0]   ys;
      logic signed [CB-1:0]   xe;
      logic signed [CB-1:0]   ye;
      logic [COLOUR_BITS-1:0] red;
      logic [COLOUR_BITS-1:0] green;
      logic [COLOUR_BITS-1:0] blue;
   } draw_command_t;

   typedef struct packed {
      logic signed [CB-1:0]  x;
      logic signed [CB-1:0]  y;
      logic [INDEX_BITS-1:0] index;
      colour_type            colour;
      logic                  in_frame;
      logic                  last;
   } pixel_t;

   // All inputs of the block start at known values; reset is high from time 0.
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_operation = OP_STEP;
   logic signed [CB-1:0]        req_x_start = '0;
   logic signed [CB-1:0]        req_y_start = '0;
   logic signed [CB-1:0]        req_x_end = '0;
   logic signed [CB-1:0]        req_y_end = '0;
   logic [COLOUR_BITS-1:0]      req_red_in = '0;
   logic [COLOUR_BITS-1:0]      req_green_in = '0;
   logic [COLOUR_BITS-1:0]      req_blue_in = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [CB-1:0]        rsp_pixel_x;
   logic signed [CB-1:0]        rsp_pixel_y;
   logic [INDEX_BITS-1:0]       rsp_pixel_index;
   logic [COLOUR_BITS-1:0]      rsp_red_out;
   logic [COLOUR_BITS-1:0]      rsp_green_out;
   logic [COLOUR_BITS-1:0]      rsp_blue_out;
   logic                        rsp_in_frame;
   logic                        rsp_last_pixel;
   logic                        csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index = CSR_FRAME_WIDTH;
   logic [DIM_BITS-1:0]         csr_wdata = '0;

   draw_command_t draw_commands[$];
   pixel_t        expected_pixels[$];

   // Shadow copy of the frame registers and the line walker state.
   int         frame_w;
   int         frame_h;
   bit         line_on;
   bit         steep;
   int         lead_pos;
   int         lead_end;
   int         side_pos;
   bit         side_down;
   int         err_acc;
   int         lead_span;
   int         err_step;
   colour_type line_rgb;

   int errors = 0;
   int loads_seen = 0;
   int steps_seen = 0;
   int pixels_checked = 0;
   int pixels_in_frame = 0;
   int lines_finished = 0;
   int settings_used = 1;
   int burst_left = 1;
   int gap_left = 0;
   int quiet_cycles = 0;
   logic [5:0] stall_tick = '0;
   logic [1:0] stall_mode = '0;

   line_pixel_generator #(.COORD_BITS(CB)) i_dut (.*);

   always #2 clock = ~clock;

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int clamp_coord(input int v);
      return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
   endfunction

   function automatic int any_coord();
      return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
   endfunction

   // Behavioral rasterizer. A load sets up the walker and yields nothing; a
   // step yields the current pixel and advances along the major axis. Returns
   // 1 when the command produces a pixel.
   function automatic bit rasterize(input draw_command_t cmd, output pixel_t pix);
      int ax, ay, bx, by, ma, na, mb, nb, tmp, px, py, acc;
      bit in_view;
      pix = '0;
      if (cmd.op == OP_LOAD) begin
         ax = int'(cmd.xs);
         ay = int'(cmd.ys);
         bx = int'(cmd.xe);
         by = int'(cmd.ye);
         // A 45 degree line is not steep, so x stays the major axis.
         steep = magnitude(bx - ax) < magnitude(by - ay);
         if (steep) begin
            ma = ay; na = ax; mb = by; nb = bx;
         end else begin
            ma = ax; na = ay; mb = bx; nb = by;
         end
         if (mb < ma) begin
            tmp = ma; ma = mb; mb = tmp;
            tmp = na; na = nb; nb = tmp;
         end
         lead_pos     = ma;
         lead_end     = mb;
         side_pos     = na;
         side_down    = !(nb > na);
         lead_span    = mb - ma;
         err_step     = 2 * magnitude(nb - na);
         err_acc      = 0;
         line_rgb.red   = cmd.red;
         line_rgb.green = cmd.green;
         line_rgb.blue  = cmd.blue;
         line_on      = 1'b1;
         return 1'b0;
      end
      if (!line_on) return 1'b0;
      px = steep ? side_pos : lead_pos;
      py = steep ? lead_pos : side_pos;
      in_view = px >= 0 && py >= 0 && px < frame_w && py < frame_h;
      pix.x        = CB'(px);
      pix.y        = CB'(py);
      pix.index    = in_view ? INDEX_BITS'(frame_w * py + px) : '0;
      pix.colour   = line_rgb;
      pix.in_frame = in_view;
      pix.last     = (lead_pos == lead_end);
      if (pix.last) begin
         line_on = 1'b0;
      end else begin
         acc = err_acc + err_step;
         if (acc > lead_span) begin
            side_pos += side_down ? -1 : 1;
            acc -= 2 * lead_span;
         end
         err_acc = acc;
         lead_pos += 1;
      end
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   task automatic push_load(input int xs, input int ys, input int xe, input int ye,
                            input int red, input int green, input int blue);
      draw_command_t cmd;
      cmd.op    = OP_LOAD;
      cmd.xs    = CB'(xs);
      cmd.ys    = CB'(ys);
      cmd.xe    = CB'(xe);
      cmd.ye    = CB'(ye);
      cmd.red   = COLOUR_BITS'(red);
      cmd.green = COLOUR_BITS'(green);
      cmd.blue  = COLOUR_BITS'(blue);
      draw_commands.push_back(cmd);
   endtask

   // Step transfers carry random junk in the load-only fields, which the block
   // must ignore.
   task automatic push_steps(input int count);
      draw_command_t cmd;
      repeat (count) begin
         cmd.op    = OP_STEP;
         cmd.xs    = CB'(any_coord());
         cmd.ys    = CB'(any_coord());
         cmd.xe    = CB'(any_coord());
         cmd.ye    = CB'(any_coord());
         cmd.red   = COLOUR_BITS'($urandom_range(0, 255));
         cmd.green = COLOUR_BITS'($urandom_range(0, 255));
         cmd.blue  = COLOUR_BITS'($urandom_range(0, 255));
         draw_commands.push_back(cmd);
      end
   endtask

   // Queues one line. Most lines are loaded and then stepped out to their last
   // pixel. Some are cut short so that the next load replaces them, some get
   // extra steps that land on an idle block, and a few have endpoints anywhere
   // in the coordinate range with only a handful of steps.
   task automatic queue_random_line(input int fw, input int fh, output int added);
      int xs, ys, xe, ye, reach, pixels, steps, kind;
      kind  = $urandom_range(0, 11);
      reach = ($urandom_range(0, 9) == 0) ? 200 : 20;
      if (kind == 0) begin
         xs = any_coord();
         ys = any_coord();
         xe = any_coord();
         ye = any_coord();
      end else begin
         if ($urandom_range(0, 3) == 0) begin
            xs = any_coord();
            ys = any_coord();
         end else begin
            // Start near the frame so that edges and the inside are both hit.
            xs = clamp_coord(int'($urandom_range(0, fw + 16)) - 8);
            ys = clamp_coord(int'($urandom_range(0, fh + 16)) - 8);
         end
         xe = clamp_coord(xs + int'($urandom_range(0, 2 * reach)) - reach);
         ye = clamp_coord(ys + int'($urandom_range(0, 2 * reach)) - reach);
      end
      pixels = magnitude(xe - xs);
      if (magnitude(ye - ys) > pixels) pixels = magnitude(ye - ys);
      pixels++;
      case (kind)
         0: steps = $urandom_range(0, 6);
         1: steps = $urandom_range(0, pixels - 1);
         2: steps = pixels + int'($urandom_range(1, 3));
         default: steps = pixels;
      endcase
      push_load(xs, ys, xe, ye, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255));
      push_steps(steps);
      added = 1 + steps;
   endtask

   // Waits until every queued command has been accepted and every predicted
   // pixel has come back, then lets the block settle. Sampling on the falling
   // edge keeps this clear of the updates made at the rising edge.
   task automatic wait_idle();
      do @(negedge clock);
      while (draw_commands.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [DIM_BITS-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   // Sender. It works in bursts of random length separated by random gaps,
   // and a payload is held steady until its transfer completes.
   always @(posedge clock) begin : driver
      draw_command_t cmd;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (draw_commands.size() != 0) begin
            cmd = draw_commands.pop_front();
            req_valid     <= 1'b1;
            req_operation <= cmd.op;
            req_x_start   <= cmd.xs;
            req_y_start   <= cmd.ys;
            req_x_end     <= cmd.xe;
            req_y_end     <= cmd.ye;
            req_red_in    <= cmd.red;
            req_green_in  <= cmd.green;
            req_blue_in   <= cmd.blue;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               case ($urandom_range(0, 5))
                  0, 1, 2: gap_left <= 0;
                  3, 4:    gap_left <= $urandom_range(1, 4);
                  default: gap_left <= $urandom_range(5, 30);
               endcase
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. When its tick counter wraps to zero it picks a new stall pattern:
   // none at all, sparse random stalls, a regular pattern from the low tick bits,
   // or heavy back-pressure that fills the output buffer.
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1'b1;
      if (stall_tick == '0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
         2'd0:    rsp_stall <= 1'b0;
         2'd1:    rsp_stall <= ($urandom_range(0, 2) == 0);
         2'd2:    rsp_stall <= (stall_tick[2:0] < 3'd5);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Scoreboard. At each rising edge it checks an accepted pixel against the
   // oldest prediction, runs the rasterizer on an accepted command, and
   // mirrors register writes into the shadow copy.
   always @(posedge clock) begin : scoreboard
      draw_command_t seen;
      pixel_t        want;
      if (reset) begin
         frame_w   = int'(FRAME_WIDTH_RESET);
         frame_h   = int'(FRAME_HEIGHT_RESET);
         line_on   = 1'b0;
         steep     = 1'b0;
         lead_pos  = 0;
         lead_end  = 0;
         side_pos  = 0;
         side_down = 1'b0;
         err_acc   = 0;
         lead_span = 0;
         err_step  = 0;
         line_rgb  = '0;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               errors++;
               $display("%0t: pixel (%0d,%0d) arrived with nothing expected", $time,
                        rsp_pixel_x, rsp_pixel_y);
            end else begin
               want = expected_pixels.pop_front();
               check_field("pixel_x", int'(want.x), int'(rsp_pixel_x));
               check_field("pixel_y", int'(want.y), int'(rsp_pixel_y));
               check_field("pixel_index", int'(want.index), int'(rsp_pixel_index));
               check_field("red_out", int'(want.colour.red), int'(rsp_red_out));
               check_field("green_out", int'(want.colour.green), int'(rsp_green_out));
               check_field("blue_out", int'(want.colour.blue), int'(rsp_blue_out));
               check_field("in_frame", int'(want.in_frame), int'(rsp_in_frame));
               check_field("last_pixel", int'(want.last), int'(rsp_last_pixel));
               pixels_checked++;
               if (want.in_frame) pixels_in_frame++;
               if (want.last) lines_finished++;
            end
         end
         if (req_valid && !req_stall) begin
            seen.op    = req_operation;
            seen.xs    = req_x_start;
            seen.ys    = req_y_start;
            seen.xe    = req_x_end;
            seen.ye    = req_y_end;
            seen.red   = req_red_in;
            seen.green = req_green_in;
            seen.blue  = req_blue_in;
            if (seen.op == OP_LOAD) loads_seen++;
            else steps_seen++;
            if (rasterize(seen, want)) expected_pixels.push_back(want);
         end
         if (csr_write) begin
            if (csr_index == CSR_FRAME_WIDTH) frame_w = int'(csr_wdata);
            else if (csr_index == CSR_FRAME_HEIGHT) frame_h = int'(csr_wdata);
         end
      end
   end

   // Watchdog: a long run of cycles with no transfer on any port means the
   // block has hung or lost a pixel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d pixels still expected", $time,
                  QUIET_LIMIT, expected_pixels.size());
         $display("tb_top: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int fw, fh, added, queued;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, run with the reset frame of 800 by 600.
      push_steps(1);                                   // no line loaded yet
      push_load(3, 4, 3, 4, 0, 0, 0);                  // single-point line
      push_steps(2);                                   // the second step finds no line
      push_load(COORD_MIN, COORD_MAX, COORD_MIN + 2, COORD_MAX, 255, 255, 255);
      push_steps(3);
      push_load(COORD_MAX, COORD_MIN, COORD_MAX - 1, COORD_MIN + 3, 8'h55, 8'hAA, 8'h0F);
      push_steps(4);                                   // steep, x walks down
      push_load(5, 5, 2, 2, 1, 2, 3);                  // 45 degrees, reversed endpoints
      push_steps(2);                                   // cut short by the next load
      push_load(798, 599, 801, 598, 200, 100, 50);     // across the right frame edge
      push_steps(4);
      push_load(-1, -1, 1, 1, 9, 8, 7);                // across the top left corner
      push_steps(3);

      // Random part. Each phase starts from an idle block with a new frame
      // size, the extremes among them, including a zero width.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0:       begin fw = 2047; fh = 2047; end
            1:       begin fw = 1;    fh = 1;    end
            2:       begin fw = 0;    fh = 600;  end
            3:       begin fw = 64;   fh = 48;   end
            4:       begin fw = 2047; fh = 1;    end
            5:       begin fw = 3;    fh = 0;    end
            default: begin fw = $urandom_range(1, 2047); fh = $urandom_range(1, 2047); end
         endcase
         write_register(CSR_FRAME_WIDTH, DIM_BITS'(fw));
         write_register(CSR_FRAME_HEIGHT, DIM_BITS'(fh));
         if (phase == 3) begin
            write_register(CSR_UNMAPPED_2, DIM_BITS'($urandom_range(0, 2047)));
            write_register(CSR_UNMAPPED_3, DIM_BITS'($urandom_range(0, 2047)));
         end
         @(posedge clock);
         csr_write <= 1'b0;
         @(negedge clock);
         settings_used++;
         queued = 0;
         while (queued < ITEMS_PER_PHASE) begin
            queue_random_line(fw, fh, added);
            queued += added;
         end
      end

      wait_idle();
      if (expected_pixels.size() != 0) begin
         errors++;
         $display("%0t: %0d pixels never arrived", $time, expected_pixels.size());
      end
      $display("summary: %0d loads and %0d steps over %0d frame sizes", loads_seen,
               steps_seen, settings_used);
      $display("summary: %0d pixels compared, %0d inside the frame, %0d line ends",
               pixels_checked, pixels_in_frame, lines_finished);
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/lpg_pkg.sv
rtl/lpg_line_state.sv
rtl/lpg_pixel_clip.sv
rtl/lpg_out_buffer.sv
rtl/line_pixel_generator.sv
tb/tb_top.sv
